@@ sv/qmi_pkg.sv @@
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared widths and the pipeline payload type for the quaternion
// multiply-by-inverse block.
// ----------------------------------------------------------------------------
package qmi_pkg;

  localparam int FRAC_BITS = 14;
  localparam int TAG_W     = 5;
  localparam int DW        = 16;               // component width
  localparam int PRW       = 2 * DW;           // one product
  localparam int PW        = PRW + 2;          // signed sum of four products
  localparam int NW        = PRW + 1;          // norm squared, unsigned
  localparam int MW        = PW - 1;           // magnitude of a sum
  localparam int AW        = MW + FRAC_BITS;   // scaled dividend
  localparam int QB        = DW;               // quotient bits computed
  localparam int RW        = NW;               // partial remainder
  localparam int LANES     = 4;

  localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_MAX = {1'b1, {(QB-1){1'b0}}};

  typedef struct packed {
    logic [TAG_W-1:0]              tag;
    logic                          zero;
    logic [NW-1:0]                 n;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0]              ov;
    logic [LANES-1:0][RW-1:0]      rem;
    logic [LANES-1:0][QB-1:0]      lo;
    logic [LANES-1:0][QB-1:0]      q;
  } div_t;

endpackage

@@ sv/qmi_front.sv @@
// ----------------------------------------------------------------------------
// qmi_front
// Products, sums, norm and dividend setup: three register stages that feed
// the divider chain.
// ----------------------------------------------------------------------------
module qmi_front import qmi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [TAG_W-1:0]        tag_i,
  input  logic signed [DW-1:0]    mw_i,
  input  logic signed [DW-1:0]    mx_i,
  input  logic signed [DW-1:0]    my_i,
  input  logic signed [DW-1:0]    mz_i,
  input  logic signed [DW-1:0]    gw_i,
  input  logic signed [DW-1:0]    gx_i,
  input  logic signed [DW-1:0]    gy_i,
  input  logic signed [DW-1:0]    gz_i,
  output logic                    valid_o,
  output div_t                    div_o
);

  // stage 1: products
  logic                   v1_q;
  logic [TAG_W-1:0]       tag1_q;
  logic signed [PRW-1:0]  pr_q [16];
  logic signed [PRW-1:0]  sq_q [4];

  // stage 2: sums
  logic                   v2_q;
  logic [TAG_W-1:0]       tag2_q;
  logic signed [PW-1:0]   p_q [LANES];
  logic [NW-1:0]          n_q;

  // stage 3: dividend setup
  logic                   v3_q;
  div_t                   div_q;
  div_t                   div_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q  <= tag_i;
    pr_q[0]  <= gw_i * mw_i;
    pr_q[1]  <= gx_i * mx_i;
    pr_q[2]  <= gy_i * my_i;
    pr_q[3]  <= gz_i * mz_i;
    pr_q[4]  <= gw_i * mx_i;
    pr_q[5]  <= gx_i * mw_i;
    pr_q[6]  <= gy_i * mz_i;
    pr_q[7]  <= gz_i * my_i;
    pr_q[8]  <= gw_i * my_i;
    pr_q[9]  <= gx_i * mz_i;
    pr_q[10] <= gy_i * mw_i;
    pr_q[11] <= gz_i * mx_i;
    pr_q[12] <= gw_i * mz_i;
    pr_q[13] <= gx_i * my_i;
    pr_q[14] <= gy_i * mx_i;
    pr_q[15] <= gz_i * mw_i;
    sq_q[0]  <= mw_i * mw_i;
    sq_q[1]  <= mx_i * mx_i;
    sq_q[2]  <= my_i * my_i;
    sq_q[3]  <= mz_i * mz_i;
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= tag1_q;
    p_q[0] <= PW'(pr_q[0]) + PW'(pr_q[1]) + PW'(pr_q[2]) + PW'(pr_q[3]);
    p_q[1] <= PW'(pr_q[5]) + PW'(pr_q[7]) - PW'(pr_q[4]) - PW'(pr_q[6]);
    p_q[2] <= PW'(pr_q[9]) + PW'(pr_q[10]) - PW'(pr_q[8]) - PW'(pr_q[11]);
    p_q[3] <= PW'(pr_q[14]) + PW'(pr_q[15]) - PW'(pr_q[12]) - PW'(pr_q[13]);
    // squares are never negative, so each is zero-extended as unsigned
    n_q    <= NW'(sq_q[0][PRW-1:0]) + NW'(sq_q[1][PRW-1:0])
            + NW'(sq_q[2][PRW-1:0]) + NW'(sq_q[3][PRW-1:0]);
  end

  always_comb begin
    logic [MW-1:0] mag;
    logic [AW-1:0] a;
    div_d      = '0;
    div_d.tag  = tag2_q;
    div_d.n    = n_q;
    div_d.zero = (n_q == '0);
    for (int l = 0; l < LANES; l++) begin
      div_d.neg[l] = p_q[l][PW-1];
      mag = p_q[l][PW-1] ? MW'(-p_q[l]) : MW'(p_q[l]);
      a   = {mag, {FRAC_BITS{1'b0}}} + AW'(n_q >> 1);
      // quotient would need more than QB bits
      div_d.ov[l]  = (AW'(a >> QB) >= AW'(n_q));
      div_d.rem[l] = RW'(a >> QB);
      div_d.lo[l]  = a[QB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;

endmodule

@@ sv/qmi_div_step.sv @@
// ----------------------------------------------------------------------------
// qmi_div_step
// One restoring-division step for all four lanes: one quotient bit each,
// registered.
// ----------------------------------------------------------------------------
module qmi_div_step import qmi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  div_t  div_i,
  output logic  valid_o,
  output div_t  div_o
);

  logic v_q;
  div_t div_q;
  div_t div_d;

  always_comb begin
    logic [RW:0] t;
    div_d = div_i;
    for (int l = 0; l < LANES; l++) begin
      t = {div_i.rem[l], div_i.lo[l][QB-1]};
      if (t >= (RW+1)'(div_i.n)) begin
        div_d.rem[l] = RW'(t - (RW+1)'(div_i.n));
        div_d.q[l]   = {div_i.q[l][QB-2:0], 1'b1};
      end else begin
        div_d.rem[l] = RW'(t);
        div_d.q[l]   = {div_i.q[l][QB-2:0], 1'b0};
      end
      div_d.lo[l] = {div_i.lo[l][QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = v_q;
  assign div_o   = div_q;

endmodule

@@ sv/quaternion_multiply_by_inverse.sv @@
// ----------------------------------------------------------------------------
// quaternion_multiply_by_inverse
// Returns goal * meas^-1 in signed fixed point, rounded and saturated.
// ----------------------------------------------------------------------------
// A request is taken on every cycle start_i is high; busy_o is always low.
// Each result appears on valid_o in order, for one cycle: the receiver
// cannot stall. A request passes through three stages of multiply, sum and
// setup, then the 16-step restoring divider (one quotient bit per stage),
// then the saturation output register. A zero measured quaternion gives
// zeros with zero_norm_o set.
module quaternion_multiply_by_inverse import qmi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [TAG_W-1:0]      joint_tag_i,
  input  logic signed [DW-1:0]  meas_w_i,
  input  logic signed [DW-1:0]  meas_x_i,
  input  logic signed [DW-1:0]  meas_y_i,
  input  logic signed [DW-1:0]  meas_z_i,
  input  logic signed [DW-1:0]  goal_w_i,
  input  logic signed [DW-1:0]  goal_x_i,
  input  logic signed [DW-1:0]  goal_y_i,
  input  logic signed [DW-1:0]  goal_z_i,
  output logic                  valid_o,
  output logic [TAG_W-1:0]      tag_out_o,
  output logic signed [DW-1:0]  rot_w_o,
  output logic signed [DW-1:0]  rot_x_o,
  output logic signed [DW-1:0]  rot_y_o,
  output logic signed [DW-1:0]  rot_z_o,
  output logic                  zero_norm_o
);

  logic          v [QB+1];
  div_t          d [QB+1];

  logic                 v_q;
  logic [TAG_W-1:0]     tag_q;
  logic [LANES-1:0][DW-1:0] rot_q;
  logic [LANES-1:0][DW-1:0] rot_d;
  logic                 zero_q;

  assign busy_o = 1'b0;

  qmi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .tag_i   (joint_tag_i),
    .mw_i    (meas_w_i),
    .mx_i    (meas_x_i),
    .my_i    (meas_y_i),
    .mz_i    (meas_z_i),
    .gw_i    (goal_w_i),
    .gx_i    (goal_x_i),
    .gy_i    (goal_y_i),
    .gz_i    (goal_z_i),
    .valid_o (v[0]),
    .div_o   (d[0])
  );

  for (genvar s = 0; s < QB; s++) begin : g_div
    qmi_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[s]),
      .div_i   (d[s]),
      .valid_o (v[s+1]),
      .div_o   (d[s+1])
    );
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (d[QB].zero) begin
        rot_d[l] = '0;
      end else if (d[QB].neg[l]) begin
        if (d[QB].ov[l] || (d[QB].q[l] > NEG_MAX)) begin
          rot_d[l] = NEG_MAX;
        end else begin
          rot_d[l] = DW'(-d[QB].q[l]);
        end
      end else begin
        if (d[QB].ov[l] || (d[QB].q[l] > POS_MAX)) begin
          rot_d[l] = POS_MAX;
        end else begin
          rot_d[l] = d[QB].q[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= d[QB].tag;
    zero_q <= d[QB].zero;
    rot_q  <= rot_d;
  end

  assign valid_o     = v_q;
  assign tag_out_o   = tag_q;
  assign zero_norm_o = zero_q;
  assign rot_w_o     = rot_q[0];
  assign rot_x_o     = rot_q[1];
  assign rot_y_o     = rot_q[2];
  assign rot_z_o     = rot_q[3];

endmodule
